FILE: hw/rtl/wdt_pkg.sv
// Shared types and constants for the watchdog timer register block.
package wdt_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  localparam int unsigned AddrW = 10;
  localparam int unsigned DataW = 32;

  localparam logic [AddrW-1:0] ADDR_LOAD  = 10'd0;
  localparam logic [AddrW-1:0] ADDR_VALUE = 10'd1;
  localparam logic [AddrW-1:0] ADDR_CTL   = 10'd2;
  localparam logic [AddrW-1:0] ADDR_ICR   = 10'd3;
  localparam logic [AddrW-1:0] ADDR_RIS   = 10'd4;
  localparam logic [AddrW-1:0] ADDR_MIS   = 10'd5;
  localparam logic [AddrW-1:0] ADDR_TEST  = 10'd262;
  localparam logic [AddrW-1:0] ADDR_LOCK  = 10'd768;

  localparam logic [DataW-1:0] CTL_READY  = 32'h8000_0000;
  localparam int unsigned      CTL_NMI_BIT   = 2;
  localparam int unsigned      CTL_RESEN_BIT = 1;
  localparam int unsigned      CTL_EN_BIT    = 0;
  localparam int unsigned      TEST_STALL_BIT = 8;
  localparam logic [DataW-1:0] LOCK_KEY   = 32'h1ACC_E551;
  localparam logic [DataW-1:0] ALL_ONES   = 32'hFFFF_FFFF;

  // One result of a step.
  typedef struct packed {
    logic             sys_reset;
    logic             irq_is_nmi;
    logic             irq_out;
    logic [DataW-1:0] rdata;
  } res_t;

endpackage

FILE: hw/rtl/watchdog_timer_registers_unit.sv
// Top level of the watchdog timer register block: stream ports and pipeline registers.
//
//  channel  | direction | tdata (low bit up)                        | tuser
//  s_axis   | in        | addr[9:0] wdata[41:10] halted[42] 0-pad   | cmd[1:0]
//  m_axis   | out       | rdata[31:0] irq_out[32] irq_is_nmi[33]    | -
//           |           | sys_reset[34] 0-pad                       |
//
// A request lands in the input register, is executed against the watchdog state
// as it moves into the result register, and is offered from the result register:
// one request per cycle sustained while the output does not stall. The state
// update (decrement or register write) is made on that move. Reset is asynchronous
// and clears both stage valids and all watchdog state. An output stall holds the
// result register; the input register keeps taking a request while the result
// register waits, then holds too.
module watchdog_timer_registers_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // addr[9:0], wdata[41:10], halted[42], zero pad
  input  logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // rdata[31:0], irq_out, irq_is_nmi, sys_reset, pad
);
  import wdt_pkg::*;

  logic             in_vld_q;
  cmd_e             cmd_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] wdata_q;
  logic             halted_q;
  logic             out_vld_q;
  res_t             res_q, res_d;
  logic             advance;

  // Execute the held request whenever the result register is free or draining.
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  // Payload: capture on accept only.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q    <= cmd_e'(s_axis_tuser_i);
      addr_q   <= s_axis_tdata_i[9:0];
      wdata_q  <= s_axis_tdata_i[41:10];
      halted_q <= s_axis_tdata_i[42];
    end
  end

  wdt_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .cmd_i   (cmd_q),
    .addr_i  (addr_q),
    .wdata_i (wdata_q),
    .halted_i(halted_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, res_q.sys_reset, res_q.irq_is_nmi, res_q.irq_out,
                            res_q.rdata};

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q)
    else $error("held request dropped");
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_vld_q && out_vld_q && !m_axis_tready_i)
    else $error("input stalled without a full pipe");
  a_result_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("executed request has no result");
`endif

endmodule

FILE: hw/rtl/wdt_core.sv
// Watchdog state registers and the single-step update and read logic.
module wdt_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  wdt_pkg::cmd_e             cmd_i,
  input  logic [wdt_pkg::AddrW-1:0] addr_i,
  input  logic [wdt_pkg::DataW-1:0] wdata_i,
  input  logic                      halted_i,
  output wdt_pkg::res_t             res_o
);
  import wdt_pkg::*;

  logic [DataW-1:0] reload_q, reload_d;
  logic [DataW-1:0] count_q, count_d;
  logic en_q, en_d, nmi_q, nmi_d, resen_q, resen_d;
  logic raw_q, raw_d, stall_q, stall_d, locked_q, locked_d;

  always_comb begin
    reload_d = reload_q;
    count_d  = count_q;
    en_d     = en_q;
    nmi_d    = nmi_q;
    resen_d  = resen_q;
    raw_d    = raw_q;
    stall_d  = stall_q;
    locked_d = locked_q;
    res_o    = '0;
    case (cmd_i)
      CMD_TICK: begin
        if (en_q && !(stall_q && halted_i)) begin
          if (count_q == '0) begin
            count_d = reload_q;
            res_o.sys_reset = raw_q && resen_q;
            raw_d = 1'b1;
          end else begin
            count_d = count_q - DataW'(1);
          end
        end
      end
      CMD_READ: begin
        unique case (addr_i)
          ADDR_LOAD:  res_o.rdata = reload_q;
          ADDR_VALUE: res_o.rdata = count_q;
          ADDR_CTL: begin
            res_o.rdata = CTL_READY;
            res_o.rdata[CTL_NMI_BIT]   = nmi_q;
            res_o.rdata[CTL_RESEN_BIT] = resen_q;
            res_o.rdata[CTL_EN_BIT]    = en_q;
          end
          ADDR_RIS:   res_o.rdata = {{(DataW-1){1'b0}}, raw_q};
          ADDR_MIS:   res_o.rdata = {{(DataW-1){1'b0}}, raw_q & en_q};
          ADDR_TEST:  res_o.rdata[TEST_STALL_BIT] = stall_q;
          ADDR_LOCK:  res_o.rdata = {{(DataW-1){1'b0}}, locked_q};
          default:    res_o.rdata = '0;
        endcase
      end
      CMD_WRITE: begin
        if (addr_i == ADDR_LOCK) begin
          locked_d = (wdata_i != LOCK_KEY);
        end else if (!locked_q) begin
          unique case (addr_i)
            ADDR_LOAD: begin
              reload_d = wdata_i;
              count_d  = wdata_i;
            end
            ADDR_CTL: begin
              // enable only sets; the rising edge reloads the counter
              if (wdata_i[CTL_EN_BIT] && !en_q) begin
                en_d    = 1'b1;
                count_d = reload_q;
              end
              nmi_d   = wdata_i[CTL_NMI_BIT];
              resen_d = wdata_i[CTL_RESEN_BIT];
            end
            ADDR_ICR: begin
              raw_d   = 1'b0;
              count_d = reload_q;
            end
            ADDR_TEST: stall_d = wdata_i[TEST_STALL_BIT];
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    res_o.irq_out    = raw_d & en_d;
    res_o.irq_is_nmi = nmi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= ALL_ONES;
      count_q  <= ALL_ONES;
      en_q     <= 1'b0;
      nmi_q    <= 1'b0;
      resen_q  <= 1'b0;
      raw_q    <= 1'b0;
      stall_q  <= 1'b0;
      locked_q <= 1'b0;
    end else if (step_i) begin
      reload_q <= reload_d;
      count_q  <= count_d;
      en_q     <= en_d;
      nmi_q    <= nmi_d;
      resen_q  <= resen_d;
      raw_q    <= raw_d;
      stall_q  <= stall_d;
      locked_q <= locked_d;
    end
  end

`ifndef SYNTHESIS
  a_rst_pulse_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.sys_reset |-> cmd_i == CMD_TICK && raw_q && resen_q && count_q == '0)
    else $error("sys_reset without a second timeout");
  a_enable_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_q |=> en_q)
    else $error("count enable cleared by software");
  a_locked_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && locked_q && addr_i != ADDR_LOCK |=> $stable(reload_q) && $stable(nmi_q))
    else $error("locked registers changed");
`endif

endmodule
